>>> rtl/core/system_timer_compare_regs_assert.svh
// assertion macros for the system timer compare register block
`ifndef SYSTEM_TIMER_COMPARE_REGS_ASSERT_SVH
`define SYSTEM_TIMER_COMPARE_REGS_ASSERT_SVH

// same-cycle implication, checked outside reset
`define STCR_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked outside reset
`define STCR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/core/stcr_pkg.sv
// constants and register map of the system timer compare register block
package stcr_pkg;

   // command codes
   localparam logic [1:0] CMD_TICK  = 2'd0;
   localparam logic [1:0] CMD_READ  = 2'd1;
   localparam logic [1:0] CMD_WRITE = 2'd2;

   // address space and identity reset value
   localparam int          ADDR_WORDS = 128;
   localparam logic [31:0] ID_RESET   = 32'h0000_0000;

   // standard word map
   localparam logic [6:0] W_CLC    = 7'd0;
   localparam logic [6:0] W_ID     = 7'd2;
   localparam logic [6:0] W_TIM0   = 7'd4;
   localparam logic [6:0] W_TIM6   = 7'd10;
   localparam logic [6:0] W_CAP    = 7'd11;
   localparam logic [6:0] W_CMP0   = 7'd12;
   localparam logic [6:0] W_CMP1   = 7'd13;
   localparam logic [6:0] W_CMCON  = 7'd14;
   localparam logic [6:0] W_ICR    = 7'd15;
   localparam logic [6:0] W_ISCR   = 7'd16;
   localparam logic [6:0] W_TIM0SV = 7'(32'h50 / 4);
   localparam logic [6:0] W_CAPSV  = 7'(32'h50 / 4 + 1);
   localparam logic [6:0] W_OCS    = 7'(32'hE8 / 4);
   localparam logic [6:0] W_ACCEN0 = 7'(32'hE8 / 4 + 5);

   // alternate word map
   localparam logic [6:0] ALT_ABS    = 7'(32'h020 / 4);
   localparam logic [6:0] ALT_ABS_HI = 7'(32'h024 / 4);
   localparam logic [6:0] ALT_CMP0   = 7'(32'h120 / 4);
   localparam logic [6:0] ALT_CMP1   = 7'(32'h120 / 4 + 1);
   localparam logic [6:0] ALT_CMCON  = 7'(32'h120 / 4 + 2);
   localparam logic [6:0] ALT_ICR    = 7'(32'h12C / 4);
   localparam logic [6:0] ALT_ISCR   = 7'(32'h130 / 4);

   // interrupt control bits
   localparam int ICR_CMP0EN = 0;
   localparam int ICR_CMP0IR = 1;
   localparam int ICR_CMP1IR = 5;

   // plain register slots
   localparam int          PLAIN_SLOTS = 8;
   localparam logic [2:0]  SLOT_CLC    = 3'd0;
   localparam logic [2:0]  SLOT_ID     = 3'd1;

   // result word
   typedef struct packed {
      logic        irq_pulse;
      logic [31:0] read_data;
   } rsp_word_type;

endpackage

>>> rtl/core/system_timer_compare_regs.sv
// system timer with bit-field compare behind a 32-bit word register map
// results are registered in the output entry, or in the skid entry when it is held
// throughput: one word per cycle while req_tready is high; req and rsp sides parted
// by an output buffer; req_tready drops only while both its entries hold unread results
// reset (synchronous, active high) clears counter, registers, capture and map select;
// the identity register takes its reset constant
`include "system_timer_compare_regs_assert.svh"

module system_timer_compare_regs #(
   parameter int          ADDR_WORDS = stcr_pkg::ADDR_WORDS,
   parameter logic [31:0] ID_RESET   = stcr_pkg::ID_RESET
) (
   input  logic        clock,
   input  logic        reset,
   // config
   input  logic        csr_wr_en,
   input  logic        csr_wr_data,     // alt_address_map
   // request side
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,       // word_addr[6:0], write_data[38:7], zero pad
   input  logic [1:0]  req_tuser,       // cmd[1:0]
   // response side
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata        // read_data[31:0], irq_pulse[32], zero pad
);

   localparam logic [7:0] ADDR_LIMIT = 8'(ADDR_WORDS);

   // architectural state
   logic        alt_map_ff;
   logic [63:0] counter_ff, counter_in;
   logic [31:0] compare0_ff, compare0_in;
   logic [31:0] compare1_ff, compare1_in;
   logic [31:0] cmcon_ff, cmcon_in;
   logic [31:0] icr_ff, icr_in;
   logic [31:0] capture_ff, capture_in;
   logic [31:0] plain_ff [stcr_pkg::PLAIN_SLOTS];
   logic [31:0] plain_in [stcr_pkg::PLAIN_SLOTS];

   // output buffer
   logic                   rsp_valid_ff;
   logic                   skid_valid_ff;
   stcr_pkg::rsp_word_type rsp_word_ff;
   stcr_pkg::rsp_word_type skid_word_ff;
   stcr_pkg::rsp_word_type new_word;

   // request fields
   logic [1:0]  cmd;
   logic [6:0]  word_addr;
   logic [31:0] write_data;
   logic        req_acc;
   logic        rsp_take;
   logic        mapped;
   logic [6:0]  eff_addr;
   logic        is_plain;
   logic [2:0]  plain_slot;
   logic [2:0]  tim_idx;
   logic [63:0] tick_count;
   logic        tick_match;

   assign cmd        = req_tuser;
   assign word_addr  = req_tdata[6:0];
   assign write_data = req_tdata[38:7];
   assign req_tready = !skid_valid_ff;
   assign req_acc    = req_tvalid && req_tready;
   assign rsp_take   = rsp_valid_ff && rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_word_ff.irq_pulse, rsp_word_ff.read_data};
   assign mapped     = {1'b0, word_addr} < ADDR_LIMIT;

   // alternate map remap
   always_comb begin
      eff_addr = word_addr;
      if (alt_map_ff) begin
         case (word_addr)
            stcr_pkg::ALT_ABS:    eff_addr = stcr_pkg::W_TIM0;
            stcr_pkg::ALT_ABS_HI: eff_addr = stcr_pkg::W_CAP;
            stcr_pkg::ALT_CMP0:   eff_addr = stcr_pkg::W_CMP0;
            stcr_pkg::ALT_CMP1:   eff_addr = stcr_pkg::W_CMP1;
            stcr_pkg::ALT_CMCON:  eff_addr = stcr_pkg::W_CMCON;
            stcr_pkg::ALT_ICR:    eff_addr = stcr_pkg::W_ICR;
            stcr_pkg::ALT_ISCR:   eff_addr = stcr_pkg::W_ISCR;
            default:              eff_addr = word_addr;
         endcase
      end
   end

   // plain register slot decode
   always_comb begin
      is_plain   = 1'b0;
      plain_slot = stcr_pkg::SLOT_CLC;
      if (eff_addr == stcr_pkg::W_CLC) begin
         is_plain = 1'b1;
      end else if (eff_addr == stcr_pkg::W_ID) begin
         is_plain   = 1'b1;
         plain_slot = stcr_pkg::SLOT_ID;
      end else if (eff_addr >= stcr_pkg::W_OCS && eff_addr <= stcr_pkg::W_ACCEN0) begin
         is_plain   = 1'b1;
         plain_slot = 3'(eff_addr - stcr_pkg::W_OCS) + 3'd2;
      end
   end

   assign tim_idx = 3'(eff_addr - stcr_pkg::W_TIM0);

   // compare 0 bit-field match on the incremented count
   logic [4:0]  mstart;
   logic [31:0] field_mask;
   logic [63:0] low_mask;
   logic [63:0] shifted;
   assign tick_count = counter_ff + 64'd1;
   assign mstart     = cmcon_ff[12:8];
   assign field_mask = 32'hFFFF_FFFF >> (5'd31 - cmcon_ff[4:0]);
   assign low_mask   = ~(64'hFFFF_FFFF_FFFF_FFFF << mstart);
   assign shifted    = tick_count >> mstart;
   assign tick_match = ((tick_count & low_mask) == 64'd0)
                       && ((shifted[31:0] & field_mask) == (compare0_ff & field_mask));

   // next state and result of the accepted word
   always_comb begin
      counter_in  = counter_ff;
      compare0_in = compare0_ff;
      compare1_in = compare1_ff;
      cmcon_in    = cmcon_ff;
      icr_in      = icr_ff;
      capture_in  = capture_ff;
      for (int i = 0; i < stcr_pkg::PLAIN_SLOTS; i++) begin
         plain_in[i] = plain_ff[i];
      end
      new_word.read_data = 32'd0;
      new_word.irq_pulse = 1'b0;
      case (cmd)
         stcr_pkg::CMD_TICK: begin
            counter_in = tick_count;
            if (tick_match) begin
               icr_in[stcr_pkg::ICR_CMP0IR] = 1'b1;
               new_word.irq_pulse = icr_ff[stcr_pkg::ICR_CMP0EN];
            end
         end
         stcr_pkg::CMD_READ: begin
            if (mapped) begin
               if (eff_addr >= stcr_pkg::W_TIM0 && eff_addr <= stcr_pkg::W_TIM6) begin
                  capture_in         = counter_ff[63:32];
                  new_word.read_data = 32'(counter_ff >> {tim_idx, 2'b00});
               end else if (eff_addr == stcr_pkg::W_TIM0SV) begin
                  capture_in         = counter_ff[63:32];
                  new_word.read_data = counter_ff[31:0];
               end else if (eff_addr == stcr_pkg::W_CAP || eff_addr == stcr_pkg::W_CAPSV) begin
                  new_word.read_data = capture_ff;
               end else if (eff_addr == stcr_pkg::W_CMP0) begin
                  new_word.read_data = compare0_ff;
               end else if (eff_addr == stcr_pkg::W_CMP1) begin
                  new_word.read_data = compare1_ff;
               end else if (eff_addr == stcr_pkg::W_CMCON) begin
                  new_word.read_data = cmcon_ff;
               end else if (eff_addr == stcr_pkg::W_ICR) begin
                  new_word.read_data = icr_ff;
               end else if (is_plain) begin
                  new_word.read_data = plain_ff[plain_slot];
               end
            end
         end
         stcr_pkg::CMD_WRITE: begin
            if (mapped) begin
               if (eff_addr == stcr_pkg::W_CAP) begin
                  capture_in = write_data;
               end else if (eff_addr == stcr_pkg::W_CMP0) begin
                  compare0_in = write_data;
               end else if (eff_addr == stcr_pkg::W_CMP1) begin
                  compare1_in = write_data;
               end else if (eff_addr == stcr_pkg::W_CMCON) begin
                  cmcon_in = write_data;
               end else if (eff_addr == stcr_pkg::W_ICR) begin
                  icr_in = write_data;
               end else if (eff_addr == stcr_pkg::W_ISCR) begin
                  // clears first, sets win
                  if (write_data[0]) icr_in[stcr_pkg::ICR_CMP0IR] = 1'b0;
                  if (write_data[2]) icr_in[stcr_pkg::ICR_CMP1IR] = 1'b0;
                  if (write_data[1]) icr_in[stcr_pkg::ICR_CMP0IR] = 1'b1;
                  if (write_data[3]) icr_in[stcr_pkg::ICR_CMP1IR] = 1'b1;
               end else if (is_plain) begin
                  plain_in[plain_slot] = write_data;
               end
            end
         end
         default: begin
         end
      endcase
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         alt_map_ff  <= 1'b0;
         counter_ff  <= 64'd0;
         compare0_ff <= 32'd0;
         compare1_ff <= 32'd0;
         cmcon_ff    <= 32'd0;
         icr_ff      <= 32'd0;
         capture_ff  <= 32'd0;
         for (int i = 0; i < stcr_pkg::PLAIN_SLOTS; i++) begin
            plain_ff[i] <= (i == int'(stcr_pkg::SLOT_ID)) ? ID_RESET : 32'd0;
         end
      end else begin
         if (csr_wr_en) begin
            alt_map_ff <= csr_wr_data;
         end
         if (req_acc) begin
            counter_ff  <= counter_in;
            compare0_ff <= compare0_in;
            compare1_ff <= compare1_in;
            cmcon_ff    <= cmcon_in;
            icr_ff      <= icr_in;
            capture_ff  <= capture_in;
            for (int i = 0; i < stcr_pkg::PLAIN_SLOTS; i++) begin
               plain_ff[i] <= plain_in[i];
            end
         end
      end
   end

   // two-entry output buffer control
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (rsp_take) begin
            if (skid_valid_ff) begin
               rsp_valid_ff  <= 1'b1;
               skid_valid_ff <= 1'b0;
            end else begin
               rsp_valid_ff <= req_acc;
            end
         end else if (req_acc) begin
            if (rsp_valid_ff) begin
               skid_valid_ff <= 1'b1;
            end else begin
               rsp_valid_ff <= 1'b1;
            end
         end
      end
   end

   // output buffer words
   always_ff @(posedge clock) begin
      if (rsp_take) begin
         if (skid_valid_ff) begin
            rsp_word_ff <= skid_word_ff;
         end else if (req_acc) begin
            rsp_word_ff <= new_word;
         end
      end else if (req_acc && !rsp_valid_ff) begin
         rsp_word_ff <= new_word;
      end
      if (req_acc && (skid_valid_ff || (rsp_valid_ff && !rsp_take))) begin
         skid_word_ff <= new_word;
      end
   end

   // checks
   `STCR_ASSERT_IMP(a_skid_needs_out, clock, reset, skid_valid_ff, rsp_valid_ff,
      "skid entry held while output entry empty")
   `STCR_ASSERT_NEXT(a_tick_counts, clock, reset, req_acc && (cmd == stcr_pkg::CMD_TICK),
      counter_ff == $past(counter_ff) + 64'd1, "tick did not advance the counter")
   `STCR_ASSERT_NEXT(a_access_holds_count, clock, reset,
      req_acc && (cmd != stcr_pkg::CMD_TICK), $stable(counter_ff),
      "register access moved the counter")
   `STCR_ASSERT_NEXT(a_match_sets_flag, clock, reset,
      req_acc && (cmd == stcr_pkg::CMD_TICK) && tick_match,
      icr_ff[stcr_pkg::ICR_CMP0IR], "compare match did not set the flag")

endmodule

>>> tb/system_timer_compare_regs_tb.sv
// self-checking stream testbench for the system timer compare register block
`timescale 1ns / 100ps

module system_timer_compare_regs_tb;
   import stcr_pkg::*;

   // unused command code, must be ignored by the block
   localparam logic [1:0] CMD_NONE = 2'd3;
   // first plain slot after CLC and ID
   localparam int SLOT_OCS = 2;
   localparam int CYCLE_LIMIT = 400000;

   typedef struct {
      logic [1:0]  cmd;
      logic [6:0]  addr;
      logic [31:0] data;
   } bus_op_type;

   logic        clock;
   logic        reset = 1'b1;
   logic        csr_wr_en = 1'b0;
   logic        csr_wr_data = 1'b0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;     // word_addr[6:0], write_data[38:7], zero pad
   logic [1:0]  req_tuser = '0;     // cmd[1:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;          // read_data[31:0], irq_pulse[32], zero pad

   // timer state as predicted from the accepted words
   logic [63:0] tmr_count = '0;
   logic [31:0] tmr_cmp0 = '0;
   logic [31:0] tmr_cmp1 = '0;
   logic [31:0] tmr_cmcon = '0;
   logic [31:0] tmr_icr = '0;
   logic [31:0] tmr_cap = '0;
   logic [31:0] tmr_plain [PLAIN_SLOTS];
   logic        tmr_alt_map = 1'b0;

   bus_op_type   bus_ops_q [$];
   rsp_word_type timer_results_q [$];
   bus_op_type   active_op;
   int           idle_left = 0;
   int           stall_left = 0;
   int           sent_count = 0;
   int           cycle_count = 0;
   int           error_count = 0;

   system_timer_compare_regs dut (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // plain register slot of a word, -1 if none
   function automatic int plain_slot(logic [6:0] a);
      if (a == W_CLC) return int'(SLOT_CLC);
      if (a == W_ID) return int'(SLOT_ID);
      if (a >= W_OCS && a <= W_ACCEN0) return int'(a - W_OCS) + SLOT_OCS;
      return -1;
   endfunction

   // advance the timer state by one accepted word and queue its result
   task automatic timer_access(input bus_op_type op);
      rsp_word_type want;
      logic [6:0]   a;
      logic [4:0]   mstart;
      logic [5:0]   nbits;
      logic [63:0]  fmask;
      logic [63:0]  low;
      int           slot;
      want = '0;
      a = op.addr;
      // alternate map remaps seven offsets, the rest pass through
      if (tmr_alt_map) begin
         case (op.addr)
            ALT_ABS:    a = W_TIM0;
            ALT_ABS_HI: a = W_CAP;
            ALT_CMP0:   a = W_CMP0;
            ALT_CMP1:   a = W_CMP1;
            ALT_CMCON:  a = W_CMCON;
            ALT_ICR:    a = W_ICR;
            ALT_ISCR:   a = W_ISCR;
            default:    a = op.addr;
         endcase
      end
      slot = plain_slot(a);
      case (op.cmd)
         CMD_TICK: begin
            tmr_count = tmr_count + 64'd1;
            // field compare, all bits below the field must be zero
            mstart = tmr_cmcon[12:8];
            nbits = {1'b0, tmr_cmcon[4:0]} + 6'd1;
            fmask = (nbits >= 6'd32) ? 64'hFFFF_FFFF : (64'd1 << nbits) - 64'd1;
            low = (64'd1 << mstart) - 64'd1;
            if ((tmr_count & low) == 64'd0 &&
                ((tmr_count >> mstart) & fmask) == ({32'd0, tmr_cmp0} & fmask)) begin
               tmr_icr[ICR_CMP0IR] = 1'b1;
               want.irq_pulse = tmr_icr[ICR_CMP0EN];
            end
         end
         CMD_READ: begin
            if (op.addr < ADDR_WORDS) begin
               if ((a >= W_TIM0 && a <= W_TIM6) || a == W_TIM0SV)
                  tmr_cap = tmr_count[63:32];
               if (a >= W_TIM0 && a <= W_TIM6)
                  want.read_data = 32'(tmr_count >> (4 * int'(a - W_TIM0)));
               else if (a == W_TIM0SV)
                  want.read_data = tmr_count[31:0];
               else if (a == W_CAP || a == W_CAPSV)
                  want.read_data = tmr_cap;
               else if (a == W_CMP0)
                  want.read_data = tmr_cmp0;
               else if (a == W_CMP1)
                  want.read_data = tmr_cmp1;
               else if (a == W_CMCON)
                  want.read_data = tmr_cmcon;
               else if (a == W_ICR)
                  want.read_data = tmr_icr;
               else if (slot >= 0)
                  want.read_data = tmr_plain[slot];
            end
         end
         CMD_WRITE: begin
            if (op.addr < ADDR_WORDS) begin
               if (a == W_CAP)
                  tmr_cap = op.data;
               else if (a == W_CMP0)
                  tmr_cmp0 = op.data;
               else if (a == W_CMP1)
                  tmr_cmp1 = op.data;
               else if (a == W_CMCON)
                  tmr_cmcon = op.data;
               else if (a == W_ICR)
                  tmr_icr = op.data;
               else if (a == W_ISCR) begin
                  // clears first so that sets win
                  if (op.data[0]) tmr_icr[ICR_CMP0IR] = 1'b0;
                  if (op.data[2]) tmr_icr[ICR_CMP1IR] = 1'b0;
                  if (op.data[1]) tmr_icr[ICR_CMP0IR] = 1'b1;
                  if (op.data[3]) tmr_icr[ICR_CMP1IR] = 1'b1;
               end else if (slot >= 0)
                  tmr_plain[slot] = op.data;
            end
         end
         default: ;
      endcase
      timer_results_q.push_back(want);
   endtask

   task automatic push_op(input logic [1:0] cmd, input logic [6:0] addr, input logic [31:0] data);
      bus_op_type op;
      op.cmd = cmd;
      op.addr = addr;
      op.data = data;
      bus_ops_q.push_back(op);
   endtask

   // random words, weighted toward mapped registers and matchable compare setups
   task automatic queue_random_ops(input int n);
      bus_op_type op;
      int         r;
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(0, 99);
         if (r < 45) op.cmd = CMD_TICK;
         else if (r < 70) op.cmd = CMD_READ;
         else if (r < 96) op.cmd = CMD_WRITE;
         else op.cmd = CMD_NONE;
         case ($urandom_range(0, 11))
            0:  op.addr = W_TIM0 + 7'($urandom_range(0, 6));
            1:  op.addr = $urandom_range(0, 1) ? W_CAP : W_CAPSV;
            2:  op.addr = $urandom_range(0, 1) ? W_CMP0 : ALT_CMP0;
            3:  op.addr = $urandom_range(0, 1) ? W_CMCON : ALT_CMCON;
            4:  op.addr = $urandom_range(0, 1) ? W_ICR : ALT_ICR;
            5:  op.addr = $urandom_range(0, 1) ? W_ISCR : ALT_ISCR;
            6:  op.addr = $urandom_range(0, 1) ? W_CMP1 : ALT_CMP1;
            7:  op.addr = $urandom_range(0, 1) ? ALT_ABS : ALT_ABS_HI;
            8:  op.addr = W_OCS + 7'($urandom_range(0, 5));
            9:  op.addr = $urandom_range(0, 1) ? W_CLC : W_ID;
            10: op.addr = W_TIM0SV;
            default: op.addr = 7'($urandom_range(0, ADDR_WORDS - 1));
         endcase
         op.data = $urandom;
         // keep the compare field low and narrow most of the time so ticks match
         if ((op.addr == W_CMCON || op.addr == ALT_CMCON) && $urandom_range(0, 3) != 0) begin
            op.data[12:8] = 5'($urandom_range(0, 3));
            op.data[4:0] = 5'($urandom_range(0, 5));
         end
         if ((op.addr == W_CMP0 || op.addr == ALT_CMP0) && $urandom_range(0, 3) != 0)
            op.data = $urandom_range(0, 63);
         bus_ops_q.push_back(op);
      end
   endtask

   // wait until every queued word is sent and every result has come back
   task automatic wait_drained();
      do @(negedge clock);
      while (bus_ops_q.size() != 0 || req_tvalid || timer_results_q.size() != 0);
   endtask

   // map select write, only while the block is idle
   task automatic set_address_map(input logic alt);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= alt;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      tmr_alt_map = alt;
   endtask

   // gap before the next request word: mostly none, a few long, some bursts without
   function automatic int draw_gap(input int n);
      int r;
      r = $urandom_range(0, 99);
      if (n % 300 < 60 || r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         idle_left = 0;
      end else begin
         if (req_tvalid && req_tready)
            timer_access(active_op);
         if (!req_tvalid || req_tready) begin
            if (idle_left > 0) begin
               idle_left--;
               req_tvalid <= 1'b0;
            end else if (bus_ops_q.size() > 0) begin
               active_op = bus_ops_q.pop_front();
               req_tuser <= active_op.cmd;
               req_tdata <= {1'b0, active_op.data, active_op.addr};
               req_tvalid <= 1'b1;
               idle_left = draw_gap(sent_count);
               sent_count++;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // response monitor with random back-pressure
   always @(posedge clock) begin
      rsp_word_type got;
      rsp_word_type want;
      int           r;
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.read_data = rsp_tdata[31:0];
            got.irq_pulse = rsp_tdata[32];
            if (timer_results_q.size() == 0) begin
               $display("%0t: unexpected response word, expected none, actual %h", $time,
                        rsp_tdata);
               error_count++;
            end else begin
               want = timer_results_q.pop_front();
               if (got.read_data !== want.read_data) begin
                  $display("%0t: read_data mismatch, expected %h, actual %h", $time,
                           want.read_data, got.read_data);
                  error_count++;
               end
               if (got.irq_pulse !== want.irq_pulse) begin
                  $display("%0t: irq_pulse mismatch, expected %b, actual %b", $time,
                           want.irq_pulse, got.irq_pulse);
                  error_count++;
               end
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            r = $urandom_range(0, 99);
            if (cycle_count % 512 < 100 || r < 70) stall_left = 0;
            else if (r < 93) stall_left = $urandom_range(1, 3);
            else stall_left = $urandom_range(8, 30);
         end
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // stimulus
   initial begin
      for (int i = 0; i < PLAIN_SLOTS; i++)
         tmr_plain[i] = '0;
      tmr_plain[SLOT_ID] = ID_RESET;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      set_address_map(1'b0);

      // standard map: reset values, extremes, match and flag handling
      push_op(CMD_READ, W_ID, '0);
      push_op(CMD_WRITE, W_CLC, 32'hFFFF_FFFF);
      push_op(CMD_READ, W_CLC, '0);
      push_op(CMD_WRITE, W_CMCON, 32'h0000_1F1F);
      push_op(CMD_READ, W_CMCON, '0);
      push_op(CMD_WRITE, W_CMCON, 32'h0000_0000);
      push_op(CMD_WRITE, W_CMP0, 32'h0000_0001);
      push_op(CMD_WRITE, W_ICR, 32'(1) << ICR_CMP0EN);
      push_op(CMD_TICK, W_CLC, '0);
      push_op(CMD_TICK, W_CLC, '0);
      push_op(CMD_TICK, 7'h7F, 32'hFFFF_FFFF);
      push_op(CMD_READ, W_TIM6, '0);
      push_op(CMD_WRITE, W_TIM0, 32'hFFFF_FFFF);
      push_op(CMD_READ, W_TIM0SV, '0);
      push_op(CMD_READ, W_CAPSV, '0);
      push_op(CMD_WRITE, W_ISCR, 32'h0000_000F);
      push_op(CMD_READ, W_ICR, '0);
      push_op(CMD_WRITE, W_ISCR, 32'h0000_0005);
      push_op(CMD_READ, W_ISCR, '0);
      push_op(CMD_WRITE, W_ACCEN0, 32'hA5A5_5A5A);
      push_op(CMD_READ, W_ACCEN0, '0);
      push_op(CMD_WRITE, 7'h7F, 32'hFFFF_FFFF);
      push_op(CMD_READ, 7'h7F, '0);
      push_op(CMD_NONE, W_CMP0, 32'hFFFF_FFFF);
      push_op(CMD_READ, W_CMP0, '0);
      wait_drained();

      // alternate map offsets
      set_address_map(1'b1);
      push_op(CMD_TICK, W_CLC, '0);
      push_op(CMD_READ, ALT_ABS, '0);
      push_op(CMD_WRITE, ALT_ABS_HI, 32'h1234_5678);
      push_op(CMD_READ, ALT_ABS_HI, '0);
      push_op(CMD_WRITE, ALT_CMP1, 32'hDEAD_BEEF);
      push_op(CMD_READ, ALT_CMP1, '0);
      push_op(CMD_WRITE, ALT_CMCON, 32'h0000_0100);
      push_op(CMD_READ, ALT_CMP0, '0);
      push_op(CMD_WRITE, ALT_ISCR, 32'h0000_0008);
      push_op(CMD_READ, ALT_ICR, '0);
      wait_drained();

      // random phases, map select toggled between them
      for (int p = 0; p < 6; p++) begin
         queue_random_ops(220);
         wait_drained();
         if (p < 5)
            set_address_map(p[0] ? 1'b1 : 1'b0);
      end

      repeat (10) @(posedge clock);
      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
